// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check a property that also has to hold during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/bseq_pkg.sv
// Package: sizes, codes and types of the bucketed sorted event queue.
package bseq_pkg;
    localparam int BUCKETS      = 16;
    localparam int POOL_ENTRIES = 64;
    localparam int BKT_W        = $clog2(BUCKETS);
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int PTR_W        = IDX_W + 1;
    localparam int KEY_W        = 31;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = PTR_W;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    localparam logic [2:0] KIND_ENQ    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_REQ    = 3'd2;
    localparam logic [2:0] KIND_POP    = 3'd3;
    localparam logic [2:0] KIND_PEEK   = 3'd4;
    localparam logic [2:0] KIND_COUNT  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [KEY_W-1:0]  key;
        logic [PTR_W-1:0]  prev;
        logic [PTR_W-1:0]  next;
    } entry_t;
endpackage

// File: rtl/bucketed_sorted_event_queue_top.sv
// Top level: timing wheel of sorted doubly linked buckets over one entry pool.
// One transaction in, one result out; a new transaction is taken the cycle after
// the result leaves. Entries live in a single-port entry memory (one read or one
// write a cycle, registered read data); a sequencer does every access. Enqueue
// walks back from the bucket tail past every entry whose key is not smaller,
// writes the new entry and relinks its neighbours or the bucket head and tail;
// remove and pop read the entry and relink each neighbour; requeue is a remove
// followed by an enqueue; peek reads the bucket head; count, a bad handle and an
// empty bucket are answered without an entry access. Free entries are found from
// a valid bit per entry with a priority encoder; bucket heads and tails are
// flip-flops cleared by reset, so no clearing pass is needed.
`include "assert_macros.svh"

module bucketed_sorted_event_queue_top
    import bseq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_value[31:0], key_value[62:32], entry_handle[69:63], pulse[100:70], zeros
    input  logic [103:0] s_tdata,
    input  logic [2:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], result_handle[7:2], result_data[39:8], result_key[70:40],
    // entry_count[77:71], zeros
    output logic [79:0]  m_tdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_ULRD  = 4'd2;
    localparam logic [3:0] S_ULP   = 4'd3;
    localparam logic [3:0] S_ULN   = 4'd4;
    localparam logic [3:0] S_ULNW  = 4'd5;
    localparam logic [3:0] S_ENQ   = 4'd6;
    localparam logic [3:0] S_WALK  = 4'd7;
    localparam logic [3:0] S_WCHK  = 4'd8;
    localparam logic [3:0] S_INS   = 4'd9;
    localparam logic [3:0] S_INSW  = 4'd10;
    localparam logic [3:0] S_INSF  = 4'd11;
    localparam logic [3:0] S_PEEK  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    entry_t mem [POOL_ENTRIES];
    entry_t rd_q;
    logic   mem_we, mem_re;
    logic [IDX_W-1:0] mem_addr;
    entry_t mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        else if (mem_re)
            rd_q <= mem[mem_addr];
    end

    logic [3:0] state_reg, state_next;
    logic [2:0] kind_reg;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [KEY_W-1:0] key_reg;
    logic [PTR_W-1:0] hnd_reg, hnd_next;
    logic [BKT_W-1:0] pbkt_reg;
    logic [POOL_ENTRIES-1:0] valid_reg, valid_next;
    logic [PTR_W-1:0] head_reg [BUCKETS];
    logic [PTR_W-1:0] tail_reg [BUCKETS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    entry_t cur_reg, cur_next;           // entry being unlinked, or links of the entry being inserted
    logic [PTR_W-1:0] ptr_reg, ptr_next; // walk position
    logic [IDX_W-1:0] new_reg, new_next; // slot being inserted
    logic [1:0] st_reg, st_next;
    logic [IDX_W-1:0] rh_reg, rh_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [KEY_W-1:0] rk_reg, rk_next;
    logic out_v_reg, out_v_next;

    logic hd_we, tl_we;
    logic [BKT_W-1:0] hd_b, tl_b;
    logic [PTR_W-1:0] hd_v, tl_v;

    // lowest free slot
    logic [PTR_W-1:0] free_idx;
    always_comb
    begin
        free_idx = NIL;
        for (int i = POOL_ENTRIES - 1; i >= 0; i--)
            if (!valid_reg[i])
                free_idx = PTR_W'(i);
    end

    function automatic logic live(input logic [PTR_W-1:0] p, input logic [POOL_ENTRIES-1:0] v);
        return !p[IDX_W] && v[p[IDX_W-1:0]];
    endfunction

    logic [BKT_W-1:0] kbkt, cbkt;
    assign kbkt = key_reg[BKT_W-1:0];
    assign cbkt = cur_reg.key[BKT_W-1:0];

    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, cnt_reg, rk_reg, rd_reg, rh_reg, st_reg};

    always_comb
    begin
        state_next = state_reg;
        data_next  = data_reg;
        hnd_next   = hnd_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        ptr_next   = ptr_reg;
        new_next   = new_reg;
        st_next    = st_reg;
        rh_next    = rh_reg;
        rd_next    = rd_reg;
        rk_next    = rk_reg;
        out_v_next = out_v_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_addr = '0;
        mem_wd = cur_reg;
        hd_we = 1'b0;
        tl_we = 1'b0;
        hd_b = kbkt;
        tl_b = kbkt;
        hd_v = NIL;
        tl_v = NIL;
        if (out_v_reg && m_tready)
            out_v_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = S_DISP;
                    data_next  = s_tdata[31:0];
                    hnd_next   = s_tdata[69:63];
                    st_next = ST_OK;
                    rh_next = '0;
                    rd_next = '0;
                    rk_next = '0;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (kind_reg)
                    KIND_ENQ:
                        state_next = S_ENQ;
                    KIND_REMOVE, KIND_REQ:
                    begin
                        if (live(hnd_reg, valid_reg))
                        begin
                            mem_re = 1'b1;
                            mem_addr = hnd_reg[IDX_W-1:0];
                            state_next = S_ULRD;
                        end
                        else
                            st_next = ST_BAD;
                    end
                    KIND_POP, KIND_PEEK:
                    begin
                        hnd_next = head_reg[pbkt_reg];
                        if (live(head_reg[pbkt_reg], valid_reg))
                        begin
                            mem_re = 1'b1;
                            mem_addr = head_reg[pbkt_reg][IDX_W-1:0];
                            state_next = (kind_reg == KIND_POP) ? S_ULRD : S_PEEK;
                        end
                        else
                        begin
                            st_next = ST_EMPTY;
                            if (kind_reg == KIND_PEEK)
                                rk_next = KEY_MAX;
                        end
                    end
                    default: ;
                endcase
            end
            S_PEEK:
            begin
                rk_next = rd_q.key;
                state_next = S_DONE;
            end
            S_ULRD:
            begin
                cur_next = rd_q;
                data_next = rd_q.data;
                if (kind_reg == KIND_POP)
                    rd_next = rd_q.data;
                valid_next[hnd_reg[IDX_W-1:0]] = 1'b0;
                cnt_next = cnt_reg - CNT_W'(1);
                if (rd_q.prev[IDX_W])
                begin
                    hd_we = 1'b1;
                    hd_b = rd_q.key[BKT_W-1:0];
                    hd_v = rd_q.next;
                    state_next = S_ULN;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_addr = rd_q.prev[IDX_W-1:0];
                    state_next = S_ULP;
                end
            end
            S_ULP:
            begin
                mem_we = 1'b1;
                mem_addr = cur_reg.prev[IDX_W-1:0];
                mem_wd = rd_q;
                mem_wd.next = cur_reg.next;
                state_next = S_ULN;
            end
            S_ULN:
            begin
                if (cur_reg.next[IDX_W])
                begin
                    tl_we = 1'b1;
                    tl_b = cbkt;
                    tl_v = cur_reg.prev;
                    state_next = (kind_reg == KIND_REQ) ? S_ENQ : S_DONE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_addr = cur_reg.next[IDX_W-1:0];
                    state_next = S_ULNW;
                end
            end
            S_ULNW:
            begin
                mem_we = 1'b1;
                mem_addr = cur_reg.next[IDX_W-1:0];
                mem_wd = rd_q;
                mem_wd.prev = cur_reg.prev;
                state_next = (kind_reg == KIND_REQ) ? S_ENQ : S_DONE;
            end
            S_ENQ:
            begin
                if (free_idx[IDX_W])
                begin
                    st_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    new_next = free_idx[IDX_W-1:0];
                    rh_next = free_idx[IDX_W-1:0];
                    valid_next[free_idx[IDX_W-1:0]] = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    ptr_next = tail_reg[kbkt];
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // walk back from the tail until a smaller key or the list start
                if (ptr_reg[IDX_W])
                begin
                    // insert at head
                    mem_we = 1'b1;
                    mem_addr = new_reg;
                    mem_wd = '{data: data_reg, key: key_reg, prev: NIL,
                               next: head_reg[kbkt]};
                    hd_we = 1'b1;
                    hd_v = {1'b0, new_reg};
                    cur_next.next = head_reg[kbkt];
                    cur_next.prev = NIL;
                    state_next = S_INSF;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_addr = ptr_reg[IDX_W-1:0];
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (rd_q.key < key_reg)
                begin
                    // insert after ptr: rewrite ptr with next = new
                    cur_next.prev = ptr_reg;
                    cur_next.next = rd_q.next;
                    mem_we = 1'b1;
                    mem_addr = ptr_reg[IDX_W-1:0];
                    mem_wd = rd_q;
                    mem_wd.next = {1'b0, new_reg};
                    state_next = S_INS;
                end
                else
                begin
                    ptr_next = rd_q.prev;
                    state_next = S_WALK;
                end
            end
            S_INS:
            begin
                mem_we = 1'b1;
                mem_addr = new_reg;
                mem_wd = '{data: data_reg, key: key_reg, prev: cur_reg.prev,
                           next: cur_reg.next};
                state_next = S_INSF;
            end
            S_INSF:
            begin
                // fix the follower's back link, or the tail
                if (cur_reg.next[IDX_W])
                begin
                    tl_we = 1'b1;
                    tl_v = {1'b0, new_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_addr = cur_reg.next[IDX_W-1:0];
                    state_next = S_INSW;
                end
            end
            S_INSW:
            begin
                mem_we = 1'b1;
                mem_addr = cur_reg.next[IDX_W-1:0];
                mem_wd = rd_q;
                mem_wd.prev = {1'b0, new_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            out_v_reg <= 1'b0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                head_reg[b] <= NIL;
                tail_reg[b] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            out_v_reg <= out_v_next;
            if (hd_we)
                head_reg[hd_b] <= hd_v;
            if (tl_we)
                tail_reg[tl_b] <= tl_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid && s_tready)
        begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[62:32];
            pbkt_reg <= s_tdata[70 +: BKT_W];
        end
        data_reg <= data_next;
        hnd_reg  <= hnd_next;
        cur_reg  <= cur_next;
        ptr_reg  <= ptr_next;
        new_reg  <= new_next;
        st_reg   <= st_next;
        rh_reg   <= rh_next;
        rd_reg   <= rd_next;
        rk_reg   <= rk_next;
    end

    `ASSERT_IMPL(a_cnt_match, clk, rst_n,
        (cnt_reg == CNT_W'($countones(valid_reg))), "count differs from valid bits")
    `ASSERT_IMPL(a_out_idle, clk, rst_n,
        (out_v_reg |-> state_reg == S_IDLE), "result shown while busy")
    `ASSERT_IMPL(a_no_rw, clk, rst_n,
        (!(mem_we && mem_re)), "memory read and write in one cycle")
    `ASSERT_ALWAYS(a_cnt_range, clk, (cnt_reg <= CNT_W'(POOL_ENTRIES)), "count overflow")
endmodule
